// ----- hdl/olpe_pkg.sv -----
`timescale 1ns / 1ps

package olpe_pkg;

    localparam int DATA_W  = 32;
    localparam int TOTAL_W = 9;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_ERASE  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] read_value;
        logic [TOTAL_W-1:0]       entry_total;
    } res_t;

endpackage

// ----- hdl/olpe_ram.sv -----
`timescale 1ns / 1ps

module olpe_ram
    import olpe_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
)
(
    input  logic              clk,
    input  mem_ctl_t          mem_ctl,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_ctl.rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hdl/olpe_ctrl.sv -----
`timescale 1ns / 1ps

module olpe_ctrl
    import olpe_pkg::*;
#(
    parameter int LIST_DEPTH = 16,
    parameter int IDX_W      = 4,
    parameter int CNT_W      = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        operation,
    input  logic [DATA_W-1:0] value,
    input  logic [7:0]        position,
    output mem_ctl_t          mem_ctl,
    output logic [IDX_W-1:0]  wr_addr,
    output logic [DATA_W-1:0] wr_data,
    output logic [IDX_W-1:0]  rd_addr,
    input  logic [DATA_W-1:0] rd_data,
    output logic              res_valid,
    input  logic              res_take,
    output res_t              res
);

    typedef enum logic [2:0] {
        IDLE,
        SCAN_CMP,
        MOVE_RD,
        MOVE_WR,
        RD_WAIT,
        EMIT
    } state_t;

    localparam logic [IDX_W:0]   DEPTH_S  = (IDX_W+1)'(LIST_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LIST_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LIST_DEPTH);

    state_t             state_reg,  state_next;
    logic [IDX_W-1:0]   head_reg,   head_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic [IDX_W-1:0]   scan_reg,   scan_next;
    logic [DATA_W-1:0]  value_reg,  value_next;
    logic [1:0]         status_reg, status_next;
    logic [DATA_W-1:0]  rdval_reg,  rdval_next;

    logic [IDX_W-1:0]   head_dec;
    logic               scan_last;
    logic               pos_ok;

    // physical slot of a logical offset from the front (circular buffer)
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_S)
        begin
            s = s - DEPTH_S;
        end
        return s[IDX_W-1:0];
    endfunction

    assign head_dec  = (head_reg == '0) ? LAST_IDX : head_reg - IDX_W'(1);
    assign scan_last = (CNT_W'(scan_reg) + CNT_W'(1)) == count_reg;
    assign pos_ok    = TOTAL_W'(position) < TOTAL_W'(count_reg);

    assign in_stall  = (state_reg != IDLE);
    assign res_valid = (state_reg == EMIT);
    assign res.status      = status_reg;
    assign res.read_value  = rdval_reg;
    assign res.entry_total = TOTAL_W'(count_reg);

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        scan_next   = scan_reg;
        value_next  = value_reg;
        status_next = status_reg;
        rdval_next  = rdval_reg;
        mem_ctl     = '0;
        wr_addr     = head_reg;
        wr_data     = value;
        rd_addr     = head_reg;

        unique case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    value_next  = value;
                    status_next = ST_DONE;
                    rdval_next  = '0;
                    state_next  = EMIT;
                    unique case (operation)
                        OP_INSERT:
                        begin
                            if (count_reg == FULL_CNT)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_ctl.wr_en = 1'b1;
                                wr_addr       = head_dec;
                                wr_data       = value;
                                head_next     = head_dec;
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        OP_ERASE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                            else
                            begin
                                mem_ctl.rd_en = 1'b1;
                                rd_addr       = head_reg;
                                scan_next     = '0;
                                state_next    = SCAN_CMP;
                            end
                        end
                        OP_READ:
                        begin
                            if (pos_ok)
                            begin
                                mem_ctl.rd_en = 1'b1;
                                rd_addr       = wrap_add(head_reg, IDX_W'(position));
                                state_next    = RD_WAIT;
                            end
                            else
                            begin
                                status_next = ST_RANGE;
                            end
                        end
                        default:
                        begin
                            status_next = ST_DONE;
                        end
                    endcase
                end
            end
            SCAN_CMP:
            begin
                // rd_data holds the entry at logical scan_reg
                if (rd_data == value_reg)
                begin
                    if (scan_reg == '0)
                    begin
                        head_next  = wrap_add(head_reg, IDX_W'(1));
                        count_next = count_reg - CNT_W'(1);
                        state_next = EMIT;
                    end
                    else
                    begin
                        scan_next  = scan_reg - IDX_W'(1);
                        state_next = MOVE_RD;
                    end
                end
                else if (scan_last)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = EMIT;
                end
                else
                begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = wrap_add(head_reg, scan_reg + IDX_W'(1));
                    scan_next     = scan_reg + IDX_W'(1);
                end
            end
            MOVE_RD:
            begin
                mem_ctl.rd_en = 1'b1;
                rd_addr       = wrap_add(head_reg, scan_reg);
                state_next    = MOVE_WR;
            end
            MOVE_WR:
            begin
                // entries in front of the hit move one place back, then head steps on
                mem_ctl.wr_en = 1'b1;
                wr_addr       = wrap_add(head_reg, scan_reg + IDX_W'(1));
                wr_data       = rd_data;
                if (scan_reg == '0)
                begin
                    head_next  = wrap_add(head_reg, IDX_W'(1));
                    count_next = count_reg - CNT_W'(1);
                    state_next = EMIT;
                end
                else
                begin
                    scan_next  = scan_reg - IDX_W'(1);
                    state_next = MOVE_RD;
                end
            end
            RD_WAIT:
            begin
                rdval_next = rd_data;
                state_next = EMIT;
            end
            EMIT:
            begin
                if (res_take)
                begin
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg   <= scan_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        rdval_reg  <= rdval_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count beyond list depth");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == IDLE && in_valid && operation == OP_INSERT && count_reg == FULL_CNT)
        |=> $stable(count_reg) && $stable(head_reg) && status_reg == ST_FULL)
        else $error("refused insert changed the list");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SCAN_CMP || state_reg == MOVE_RD || state_reg == MOVE_WR)
        |-> count_reg != '0)
        else $error("erase walk on an empty list");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_take) |=> res_valid && $stable(res))
        else $error("pending result changed");

endmodule

// ----- hdl/ordered_list_push_front_erase_unit.sv -----
`timescale 1ns / 1ps
// Channel  Handshake            Payload
// -------  -------------------  ----------------------------------------
// in       in_valid / in_stall  operation[1:0], value[31:0], position[7:0]
// out      out_valid/out_stall  status[1:0], read_value[31:0], entry_total[8:0]
//
// One item at a time; entries sit in a circular buffer in one synchronous RAM.
// Insert, refused insert, failed read and unused code go straight to the result;
// a read waits on the RAM first. Erase scans one entry a cycle from the front,
// then one RAM read and one write per entry moved; a miss scans every entry.
// Reset clears state, count, head and out_valid; the RAM keeps its contents.
// A stalled out side holds the result; the next item is then taken but waits
// to emit until the output register frees.

module ordered_list_push_front_erase_unit
    import olpe_pkg::*;
#(
    parameter int LIST_DEPTH = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                operation,
    input  logic signed [DATA_W-1:0]  value,
    input  logic [7:0]                position,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                status,
    output logic signed [DATA_W-1:0]  read_value,
    output logic [TOTAL_W-1:0]        entry_total
);

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    mem_ctl_t           mem_ctl;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   rd_addr;
    logic [DATA_W-1:0]  wr_data;
    logic [DATA_W-1:0]  rd_data;
    logic               res_valid;
    logic               res_take;
    res_t               res;

    logic               out_valid_reg,  out_valid_next;
    res_t               out_res_reg,    out_res_next;

    olpe_ctrl #(
        .LIST_DEPTH (LIST_DEPTH),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .value     (value),
        .position  (position),
        .mem_ctl   (mem_ctl),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    olpe_ram #(
        .DEPTH  (LIST_DEPTH),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .mem_ctl (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign res_take = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid && res_take)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_res_reg.status;
    assign read_value  = out_res_reg.read_value;
    assign entry_total = out_res_reg.entry_total;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !(res_valid && res_take))
        else $error("pending output item overwritten");

    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status != ST_DONE) |-> read_value == '0)
        else $error("failed operation returned data");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> entry_total <= TOTAL_W'(LIST_DEPTH))
        else $error("entry total beyond list depth");

endmodule

// ----- tb/ordered_list_push_front_erase_unit_tb.sv -----
`timescale 1ns / 1ps

module ordered_list_push_front_erase_unit_tb;
    import olpe_pkg::*;

    localparam int LIST_DEPTH = 16;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 600;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 64;

    typedef struct {
        logic [1:0]               op;
        logic signed [DATA_W-1:0] val;
        logic [7:0]               pos;
        int                       reps;
        bit                       pinned;
        res_t                     want;
    } plan_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [1:0]               operation = OP_INSERT;
    logic signed [DATA_W-1:0] value = '0;
    logic [7:0]               position = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] read_value;
    logic [TOTAL_W-1:0]       entry_total;

    // a typed-in expectation rides along with its item
    bit   pin_on = 1'b0;
    res_t pin_res = '0;

    logic signed [DATA_W-1:0] shelf [LIST_DEPTH];
    int                       shelf_count = 0;
    res_t                     pending_results [$];
    plan_row_t                plan [$];
    logic signed [DATA_W-1:0] value_pool [8];
    bit                       idle_on = 1'b1;
    int                       errors = 0;
    int                       quiet_cycles = 0;

    ordered_list_push_front_erase_unit #(
        .LIST_DEPTH (LIST_DEPTH)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .value       (value),
        .position    (position),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .read_value  (read_value),
        .entry_total (entry_total)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic res_t apply_list_op(input logic [1:0] op,
                                           input logic signed [DATA_W-1:0] val,
                                           input logic [7:0] pos);
        res_t r;
        int   i;
        int   hit;
        r = '0;
        case (op)
            OP_INSERT:
            begin
                if (shelf_count >= LIST_DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    for (i = shelf_count; i > 0; i--)
                        shelf[i] = shelf[i-1];
                    shelf[0] = val;
                    shelf_count++;
                end
            end
            OP_ERASE:
            begin
                hit = -1;
                for (i = 0; i < shelf_count && hit < 0; i++)
                    if (shelf[i] == val)
                        hit = i;
                if (hit < 0)
                begin
                    r.status = ST_NOT_FOUND;
                end
                else
                begin
                    // close the gap, order kept
                    for (i = hit; i + 1 < shelf_count; i++)
                        shelf[i] = shelf[i+1];
                    shelf_count--;
                end
            end
            OP_READ:
            begin
                if (pos < shelf_count)
                    r.read_value = shelf[pos];
                else
                    r.status = ST_RANGE;
            end
            default:
            begin
            end
        endcase
        r.entry_total = shelf_count[TOTAL_W-1:0];
        return r;
    endfunction

    task automatic add_row(input logic [1:0] op, input logic signed [DATA_W-1:0] val,
                           input logic [7:0] pos, input int reps, input bit pinned,
                           input logic [1:0] st, input logic signed [DATA_W-1:0] rd,
                           input logic [TOTAL_W-1:0] total);
        plan_row_t row;
        row.op = op;
        row.val = val;
        row.pos = pos;
        row.reps = reps;
        row.pinned = pinned;
        row.want.status = st;
        row.want.read_value = rd;
        row.want.entry_total = total;
        plan.push_back(row);
    endtask

    task automatic send_op(input logic [1:0] op, input logic signed [DATA_W-1:0] val,
                           input logic [7:0] pos, input bit pinned, input res_t want);
        while (idle_on && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        value     <= val;
        position  <= pos;
        pin_on    <= pinned;
        pin_res   <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : take_in
        res_t predicted;
        if (rst_n && in_valid && !in_stall)
        begin
            predicted = apply_list_op(operation, value, position);
            pending_results.push_back(pin_on ? pin_res : predicted);
        end
    end

    always @(posedge clk)
    begin : take_out
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected item: status %0d read_value %0d entry_total %0d",
                         $time, status, read_value, entry_total);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, status);
                end
                if (read_value !== want.read_value)
                begin
                    errors++;
                    $display("%0t: read_value expected %0d actual %0d",
                             $time, want.read_value, read_value);
                end
                if (entry_total !== want.entry_total)
                begin
                    errors++;
                    $display("%0t: entry_total expected %0d actual %0d",
                             $time, want.entry_total, entry_total);
                end
            end
        end
        out_stall <= rst_n && idle_on && ($urandom_range(99) < 28);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin : run
        int                       n;
        int                       sent;
        int                       pick;
        int                       fill_bias;
        int                       erase_cut;
        logic [1:0]               op;
        logic signed [DATA_W-1:0] val;
        logic [7:0]               pos;
        res_t                     none;

        none = '0;
        fill_bias = 55;
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7FFF_FFFF;
        for (n = 2; n < 8; n++)
            value_pool[n] = $urandom;

        // empty list, then the extremes of value and position
        add_row(OP_READ,   0,             0,   1, 1, ST_RANGE,     0,             0);
        add_row(OP_ERASE,  5,             0,   1, 1, ST_NOT_FOUND, 0,             0);
        add_row(OP_UNUSED, -1,            255, 1, 1, ST_DONE,      0,             0);
        add_row(OP_INSERT, 32'sh7FFF_FFFF, 0,  1, 1, ST_DONE,      0,             1);
        add_row(OP_INSERT, 32'sh8000_0000, 0,  1, 1, ST_DONE,      0,             2);
        add_row(OP_READ,   0,             0,   1, 1, ST_DONE,      32'sh8000_0000, 2);
        add_row(OP_READ,   0,             1,   1, 1, ST_DONE,      32'sh7FFF_FFFF, 2);
        add_row(OP_READ,   0,             2,   1, 1, ST_RANGE,     0,             2);
        add_row(OP_READ,   0,             255, 1, 1, ST_RANGE,     0,             2);
        // duplicates: erase must take the one nearest the front
        add_row(OP_INSERT, -1,            0,   1, 0, ST_DONE,      0,             0);
        add_row(OP_INSERT, 0,             0,   1, 0, ST_DONE,      0,             0);
        add_row(OP_INSERT, -1,            0,   1, 0, ST_DONE,      0,             0);
        add_row(OP_ERASE,  -1,            0,   1, 0, ST_DONE,      0,             0);
        add_row(OP_READ,   0,             1,   1, 0, ST_DONE,      0,             0);
        add_row(OP_ERASE,  32'sh7FFF_FFFF, 0,  1, 0, ST_DONE,      0,             0);
        add_row(OP_ERASE,  123,           0,   1, 1, ST_NOT_FOUND, 0,             3);
        // fill to the brim
        add_row(OP_INSERT, 100,           0,  13, 0, ST_DONE,      0,             0);
        add_row(OP_INSERT, 7,             0,   1, 1, ST_FULL,      0,             16);
        add_row(OP_READ,   0,             15,  1, 0, ST_DONE,      0,             0);
        add_row(OP_READ,   0,             16,  1, 1, ST_RANGE,     0,             16);
        add_row(OP_UNUSED, 0,             0,   1, 1, ST_DONE,      0,             16);
        add_row(OP_ERASE,  32'sh8000_0000, 0,  1, 0, ST_DONE,      0,             0);
        add_row(OP_ERASE,  100,           0,  13, 0, ST_DONE,      0,             0);
        add_row(OP_READ,   0,             0,   1, 0, ST_DONE,      0,             0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[k])
            for (n = 0; n < plan[k].reps; n++)
                send_op(plan[k].op, plan[k].val + n, plan[k].pos, plan[k].pinned,
                        plan[k].want);

        // random part; swings between filling and draining phases
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            idle_on <= !(sent >= 250 && sent < 380);
            if (sent % 50 == 0)
                fill_bias = $urandom_range(1) ? 55 : 20;
            erase_cut = fill_bias + (97 - fill_bias) * 2 / 3;
            pick = $urandom_range(99);
            if (pick < fill_bias)
                op = OP_INSERT;
            else if (pick < erase_cut)
                op = OP_ERASE;
            else if (pick < 97)
                op = OP_READ;
            else
                op = OP_UNUSED;
            if ($urandom_range(99) < 75)
                val = value_pool[3'($urandom_range(7))];
            else
                val = $urandom;
            if ($urandom_range(99) < 80)
                pos = 8'($urandom_range(LIST_DEPTH + 1));
            else
                pos = 8'($urandom_range(255));
            send_op(op, val, pos, 1'b0, none);
            if (op != OP_UNUSED)
                sent++;
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
